/* hdl/tsp_pkg.sv */
// Types and constants shared by the timed step playback block.
// No dependencies.
package tsp_pkg;

    localparam int TIME_W = 32;
    localparam int HALF_W = 16;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              axis;
        logic [HALF_W-1:0] entry_time_high;
        logic [HALF_W-1:0] entry_time_low;
        logic              entry_dir;
    } tsp_in_t;

    typedef struct packed {
        logic [1:0]         step_mask;
        logic [1:0]         dir_mask;
        logic [1:0]         running_mask;
        logic               push_rejected;
        logic signed [31:0] position;
    } tsp_out_t;

    // One ring entry: direction on top, step time below.
    typedef struct packed {
        logic              dir;
        logic [TIME_W-1:0] step_time;
    } tsp_entry_t;

endpackage

/* hdl/tsp_ring.sv */
// Per-axis step ring: synchronous memory, one write and one read port.
// Depends on tsp_pkg for the entry type.
module tsp_ring import tsp_pkg::*; #(
    parameter int RING_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
    input  tsp_entry_t                    wr_data,
    input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
    output tsp_entry_t                    rd_data
);

    tsp_entry_t ring_mem [RING_DEPTH];
    tsp_entry_t rd_data_reg;
    tsp_entry_t fwd_data_reg;
    logic       fwd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= ring_mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    // write and read of the same slot in one cycle: the memory returns the
    // old word, so hand over the new one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rd_data_reg;

endmodule

/* hdl/timed_step_playback.sv */
// Timed step playback: per-axis timestamp rings driving step pulses.
// Depends on tsp_pkg and tsp_ring.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  input    | s_valid / s_ready      | s_item   (tsp_in_t)
//  result   | m_valid / m_ready      | m_result (tsp_out_t)
//
// One item per clock while s_ready is high. Control state updates at the
// accepting edge; each ring is read at the next read index so the head
// entry is ready for the following tick. The result is registered into a
// two-entry output buffer, which keeps s_ready high until both are full.
// Reset is synchronous and clears indices, flags, positions and time; ring
// contents need no clearing.
module timed_step_playback import tsp_pkg::*; #(
    parameter int AXIS_COUNT = 2,
    parameter int RING_DEPTH = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tsp_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output tsp_out_t m_result
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int MASK_W = (AXIS_COUNT > 2) ? AXIS_COUNT : 2;

    logic [AXIS_COUNT-1:0][IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [AXIS_COUNT-1:0][IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [AXIS_COUNT-1:0][31:0]      pos_reg, pos_next;
    logic [MASK_W-1:0]                run_reg, run_next;
    logic [MASK_W-1:0]                dir_reg, dir_next;
    logic [MASK_W-1:0]                step_vec;
    logic [TIME_W-1:0]                time_reg, time_next;

    logic [AXIS_COUNT-1:0] wr_en;
    tsp_entry_t            wr_entry;
    tsp_entry_t            head [AXIS_COUNT];

    logic     accept;
    logic     rejected;
    tsp_out_t result;

    tsp_out_t out_reg, out_next, skid_reg, skid_next;
    logic     out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] n;
        n = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
        return n;
    endfunction

    assign accept   = s_valid && s_ready;
    assign wr_entry = '{dir: s_item.entry_dir,
                        step_time: {s_item.entry_time_high, s_item.entry_time_low}};

    for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_ring
        tsp_ring #(
            .RING_DEPTH(RING_DEPTH)
        ) u_ring (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_en[g]),
            .wr_addr (wr_idx_reg[g]),
            .wr_data (wr_entry),
            .rd_addr (rd_idx_next[g]),
            .rd_data (head[g])
        );
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        dir_next    = dir_reg;
        time_next   = time_reg;
        step_vec    = '0;
        wr_en       = '0;
        rejected    = 1'b0;
        if (accept) begin
            unique case (s_item.kind)
                KIND_PUSH: begin
                    for (int a = 0; a < AXIS_COUNT; a++) begin
                        if (int'(s_item.axis) == a) begin
                            if (ring_next(wr_idx_reg[a]) == rd_idx_reg[a]) begin
                                rejected = 1'b1;
                            end else begin
                                wr_en[a]       = 1'b1;
                                wr_idx_next[a] = ring_next(wr_idx_reg[a]);
                            end
                        end
                    end
                end
                KIND_START: begin
                    run_next = '0;
                    for (int a = 0; a < AXIS_COUNT; a++) begin
                        run_next[a] = rd_idx_reg[a] != wr_idx_reg[a];
                    end
                    time_next = '0;
                end
                KIND_TICK: begin
                    for (int a = 0; a < AXIS_COUNT; a++) begin
                        if (run_reg[a] && head[a].step_time == time_reg) begin
                            step_vec[a]    = 1'b1;
                            dir_next[a]    = head[a].dir;
                            pos_next[a]    = head[a].dir ? pos_reg[a] + 32'd1
                                                         : pos_reg[a] - 32'd1;
                            rd_idx_next[a] = ring_next(rd_idx_reg[a]);
                            if (ring_next(rd_idx_reg[a]) == wr_idx_reg[a]) begin
                                run_next[a] = 1'b0;
                            end
                        end
                    end
                    if (run_next != '0) begin
                        time_next = time_reg + 32'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        result.step_mask     = step_vec[1:0];
        result.dir_mask      = dir_next[1:0];
        result.running_mask  = run_next[1:0];
        result.push_rejected = rejected;
        result.position      = '0;
        for (int a = 0; a < AXIS_COUNT; a++) begin
            if (int'(s_item.axis) == a) begin
                result.position = pos_next[a];
            end
        end
    end

    // two-entry result buffer
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = result;
                skid_valid_next = accept;
            end else begin
                out_next       = result;
                out_valid_next = accept;
            end
        end else if (accept) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            pos_reg        <= '0;
            run_reg        <= '0;
            dir_reg        <= '0;
            time_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            pos_reg        <= pos_next;
            run_reg        <= run_next;
            dir_reg        <= dir_next;
            time_reg       <= time_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_ready  = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    a_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg[0] |-> rd_idx_reg[0] != wr_idx_reg[0])
        else $error("axis 0 running on an empty ring");

    a_time_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.kind == KIND_TICK && run_next == '0 |=> time_reg == $past(time_reg))
        else $error("time advanced with no axis running");

    a_wr_only_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && s_item.kind == KIND_PUSH) |=> wr_idx_reg == $past(wr_idx_reg))
        else $error("write index moved without a push");

endmodule
